[hdl/bpgm_pkg.sv]
// ----------------------------------------------------------------------------
// bpgm_pkg
// Shared types, codes and helpers for the binary plane greedy mesher.
// ----------------------------------------------------------------------------
package bpgm_pkg;

	// default plane edge length in cells (rows and bits per row)
	localparam int PLANE_SIZE_DEF = 32;

	// input operation codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_MESH = 1'b1;

	// register indexes on the config port (taken from paddr[2])
	localparam logic REG_FACE_AXIS = 1'b0;
	localparam logic REG_SLICE_POS = 1'b1;

	// input transaction payload
	typedef struct packed {
		logic        func;
		logic [4:0]  row_index;
		logic [31:0] row_bits;
	} in_item_t;

	// output transaction payload
	typedef struct packed {
		logic [4:0] quad_row;
		logic [4:0] quad_start;
		logic [5:0] quad_width;
		logic [5:0] quad_height;
		logic [2:0] quad_axis;
		logic [4:0] quad_slice;
		logic       row_empty;
		logic       last;
	} out_item_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_FIND,
		ST_EXT,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic wr_load;     // write input row word into the plane store
		logic cap_item;    // capture mesh row index, read its word
		logic cap_word;    // latch the read word as remaining runs
		logic find;        // latch lowest run, read the row after it
		logic ext_hit;     // clear run from current row, read the next one
		logic emit_run;    // load a rectangle into the output register
		logic emit_empty;  // load the empty-row result
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic func;         // op code of the offered input
		logic row_ok;       // offered row lies inside the plane
		logic rem_zero;     // no runs left in the meshed row
		logic row_next_ok;  // row after the meshed row exists
		logic ext_next_ok;  // row after the current extension row exists
		logic ext_match;    // current extension row holds the whole run
		logic slot_free;    // output register can take a result
		logic last_run;     // the latched run is the final one of the row
	} status_t;

	// index of the lowest set bit; 0 when no bit is set
	function automatic logic [5:0] lsb_index(input logic [32:0] v);
		logic [5:0] idx;
		idx = '0;
		for (int i = 32; i >= 0; i--) begin
			if (v[i]) begin
				idx = 6'(i);
			end
		end
		return idx;
	endfunction

endpackage

[hdl/bpgm_ram.sv]
// ----------------------------------------------------------------------------
// bpgm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpgm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[hdl/bpgm_ctrl.sv]
// ----------------------------------------------------------------------------
// bpgm_ctrl
// Sequencer for load and mesh transactions: scan, extend, emit.
// ----------------------------------------------------------------------------
module bpgm_ctrl
	import bpgm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.func == FUNC_MESH) begin
					state_nx = sts.row_ok ? ST_READ : ST_EMPTY;
				end
			end
			ST_READ: begin
				state_nx = ST_FIND;
			end
			ST_FIND: begin
				if (sts.rem_zero) begin
					state_nx = ST_EMPTY;
				end else begin
					state_nx = sts.row_next_ok ? ST_EXT : ST_EMIT;
				end
			end
			ST_EXT: begin
				if (!sts.ext_match || !sts.ext_next_ok) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.slot_free) begin
					state_nx = sts.last_run ? ST_IDLE : ST_FIND;
				end
			end
			ST_EMPTY: begin
				if (sts.slot_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.wr_load  = in_valid && sts.func == FUNC_LOAD && sts.row_ok;
				cmd.cap_item = in_valid && sts.func == FUNC_MESH;
			end
			ST_READ: begin
				cmd.cap_word = 1'b1;
			end
			ST_FIND: begin
				cmd.find = !sts.rem_zero;
			end
			ST_EXT: begin
				cmd.ext_hit = sts.ext_match;
			end
			ST_EMIT: begin
				cmd.emit_run = sts.slot_free;
			end
			ST_EMPTY: begin
				cmd.emit_empty = sts.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[hdl/bpgm_dp.sv]
// ----------------------------------------------------------------------------
// bpgm_dp
// Plane store, run finder, extension compare/clear and output register.
// ----------------------------------------------------------------------------
module bpgm_dp
	import bpgm_pkg::*;
#(
	parameter int PLANE_SIZE = PLANE_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_data,
	input  logic [2:0] face_axis,
	input  logic [4:0] slice_pos,
	input  cmd_t       cmd,
	output status_t    sts,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	localparam int ADDR_W = $clog2(PLANE_SIZE);

	// mesh context
	logic [4:0]            row_q;
	logic [4:0]            ext_row_q;
	logic [PLANE_SIZE-1:0] rem_q;
	logic [PLANE_SIZE-1:0] run_q;
	logic [4:0]            start_q;
	logic [5:0]            height_q;
	logic [5:0]            width_q;

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	// plane store ports
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [PLANE_SIZE-1:0] wr_data;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic [PLANE_SIZE-1:0] rd_data;

	// run finder
	logic [PLANE_SIZE-1:0] low_bit;
	logic [PLANE_SIZE:0]   carry_sum;
	logic [PLANE_SIZE-1:0] run_nx;
	logic [5:0]            start_nx;
	logic [5:0]            end_nx;

	logic [5:0] row_plus;
	logic [5:0] ext_plus;

	assign row_plus = {1'b0, row_q} + 6'd1;
	assign ext_plus = {1'b0, ext_row_q} + 6'd1;

	// lowest run: adding its lowest bit carries through the run
	assign low_bit   = rem_q & (~rem_q + PLANE_SIZE'(1));
	assign carry_sum = {1'b0, rem_q} + {1'b0, low_bit};
	assign run_nx    = rem_q & ~carry_sum[PLANE_SIZE-1:0];
	assign start_nx  = lsb_index(33'(rem_q));
	assign end_nx    = lsb_index(33'(carry_sum));

	// status to controller
	assign sts.func        = in_data.func;
	assign sts.row_ok      = {1'b0, in_data.row_index} < 6'(PLANE_SIZE);
	assign sts.rem_zero    = rem_q == '0;
	assign sts.row_next_ok = row_plus < 6'(PLANE_SIZE);
	assign sts.ext_next_ok = ext_plus < 6'(PLANE_SIZE);
	assign sts.ext_match   = (rd_data & run_q) == run_q;
	assign sts.slot_free   = !out_valid_q || out_ready;
	assign sts.last_run    = (rem_q & ~run_q) == '0;

	// store access: loads from input, extension clears from run
	assign wr_en   = cmd.wr_load || cmd.ext_hit;
	assign wr_addr = cmd.wr_load ? in_data.row_index[ADDR_W-1:0] : ext_row_q[ADDR_W-1:0];
	assign wr_data = cmd.wr_load ? in_data.row_bits[PLANE_SIZE-1:0] : (rd_data & ~run_q);
	assign rd_en   = cmd.cap_item || cmd.find || cmd.ext_hit;

	always_comb begin
		if (cmd.cap_item) begin
			rd_addr = in_data.row_index[ADDR_W-1:0];
		end else if (cmd.find) begin
			rd_addr = row_plus[ADDR_W-1:0];
		end else begin
			rd_addr = ext_plus[ADDR_W-1:0];
		end
	end

	bpgm_ram #(
		.WIDTH (PLANE_SIZE),
		.DEPTH (PLANE_SIZE)
	) u_plane (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// mesh context registers
	always_ff @(posedge clk) begin
		if (cmd.cap_item) begin
			row_q <= in_data.row_index;
		end
		if (cmd.cap_word) begin
			rem_q <= rd_data;
		end else if (cmd.emit_run) begin
			rem_q <= rem_q & ~run_q;
		end
		if (cmd.find) begin
			run_q     <= run_nx;
			start_q   <= start_nx[4:0];
			height_q  <= end_nx - start_nx;
			width_q   <= 6'd1;
			ext_row_q <= row_plus[4:0];
		end else if (cmd.ext_hit) begin
			width_q   <= width_q + 6'd1;
			ext_row_q <= ext_plus[4:0];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_run || cmd.emit_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_run) begin
			out_q.quad_row    <= row_q;
			out_q.quad_start  <= start_q;
			out_q.quad_width  <= width_q;
			out_q.quad_height <= height_q;
			out_q.quad_axis   <= face_axis;
			out_q.quad_slice  <= slice_pos;
			out_q.row_empty   <= 1'b0;
			out_q.last        <= sts.last_run;
		end else if (cmd.emit_empty) begin
			out_q.quad_row    <= row_q;
			out_q.quad_start  <= '0;
			out_q.quad_width  <= '0;
			out_q.quad_height <= '0;
			out_q.quad_axis   <= face_axis;
			out_q.quad_slice  <= slice_pos;
			out_q.row_empty   <= 1'b1;
			out_q.last        <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a result is only loaded when the output register has room
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_run || cmd.emit_empty) |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	// extension never clears bits of the meshed row or an earlier one
	a_ext_above: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ext_hit |-> ext_row_q > row_q)
		else $error("extension write at or below the meshed row");

	// an emitted rectangle covers at least one cell and stays in the plane
	a_run_sane: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_run |-> (run_q != '0 && width_q != 6'd0 && width_q <= 6'(PLANE_SIZE)))
		else $error("emitted rectangle out of range");

	// after the final run of a row the controller goes back for a new item
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_run && sts.last_run) |=> (rem_q == '0))
		else $error("runs left after final rectangle");

endmodule

[hdl/binary_plane_greedy_mesher.sv]
// ----------------------------------------------------------------------------
// binary_plane_greedy_mesher
// Load item: stored, no result; the next item is taken the cycle after.
// Mesh item: the row word is read and latched, then per rectangle the lowest
// run is found, extended over later rows and emitted; an empty row gives one
// empty-row result. Rate is set by the scan of later rows and output stalls.
// Reset clears control state and the axis/slice registers; the store is not.
// ----------------------------------------------------------------------------
module binary_plane_greedy_mesher
	import bpgm_pkg::*;
#(
	parameter int PLANE_SIZE = PLANE_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0] face_axis_q;
	logic [4:0] slice_pos_q;
	logic       cfg_wr;
	cmd_t       cmd;
	status_t    sts;

	// config register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_axis_q <= '0;
			slice_pos_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FACE_AXIS: face_axis_q <= pwdata[2:0];
				REG_SLICE_POS: slice_pos_q <= pwdata[4:0];
				default:       face_axis_q <= face_axis_q;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[2])
			REG_FACE_AXIS: prdata = {29'd0, face_axis_q};
			REG_SLICE_POS: prdata = {27'd0, slice_pos_q};
			default:       prdata = '0;
		endcase
	end

	bpgm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bpgm_dp #(
		.PLANE_SIZE (PLANE_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.face_axis (face_axis_q),
		.slice_pos (slice_pos_q),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
